>>> rtl/pta_pkg.sv
// ----------------------------------------------------------------------------
// pta_pkg
// Shared types and codes for the primitive topology assembler.
// ----------------------------------------------------------------------------
package pta_pkg;

    localparam int INDEX_WIDTH_DEFAULT = 32;
    localparam int PORT_INDEX_WIDTH    = 32;
    localparam int TOPO_WIDTH          = 3;
    localparam int QUEUE_DEPTH         = 4;

    typedef logic [TOPO_WIDTH-1:0] topo_t;

    localparam topo_t TOPO_LINE_STRIP = 3'd0;
    localparam topo_t TOPO_LINE_LOOP  = 3'd1;
    localparam topo_t TOPO_TRI_STRIP  = 3'd2;
    localparam topo_t TOPO_TRI_FAN    = 3'd3;
    localparam topo_t TOPO_QUADS      = 3'd4;
    localparam topo_t TOPO_POLYGONS   = 3'd5;

    typedef logic [1:0] seen_t;
    localparam seen_t SEEN_NONE = 2'd0;
    localparam seen_t SEEN_TWO  = 2'd2;
    localparam seen_t SEEN_MAX  = 2'd3;

    // Primitive families carried from the front to the back.
    typedef logic kind_t;
    localparam kind_t KIND_LINES = 1'b0;
    localparam kind_t KIND_TRIS  = 1'b1;

    // Steps inside one job.
    // Lines: head (v0,v1), body (v1,cur), tail (cur,v0).
    // Tris : head (v0,v2,v1), body (v0,v1,cur).
    typedef logic [1:0] step_t;
    localparam step_t STEP_HEAD = 2'd0;
    localparam step_t STEP_BODY = 2'd1;
    localparam step_t STEP_TAIL = 2'd2;

    typedef struct packed {
        kind_t kind;
        step_t start_step;
        step_t end_step;
    } ctrl_t;

endpackage

>>> rtl/pta_if.sv
// ----------------------------------------------------------------------------
// pta_if
// Channel interfaces: vertex input, primitive output, topology write.
// ----------------------------------------------------------------------------
interface pta_vtx_if;
    logic                                  valid;
    logic                                  ready;
    logic [pta_pkg::PORT_INDEX_WIDTH-1:0]  vertex_index;
    logic                                  end_of_batch;
    logic                                  end_of_polygon;

    modport source (output valid, output vertex_index, output end_of_batch,
                    output end_of_polygon, input ready);
    modport sink   (input valid, input vertex_index, input end_of_batch,
                    input end_of_polygon, output ready);
endinterface

interface pta_prim_if;
    logic                                  valid;
    logic                                  ready;
    logic [pta_pkg::PORT_INDEX_WIDTH-1:0]  vertex_a;
    logic [pta_pkg::PORT_INDEX_WIDTH-1:0]  vertex_b;
    logic [pta_pkg::PORT_INDEX_WIDTH-1:0]  vertex_c;
    logic                                  last_of_run;

    modport source (output valid, output vertex_a, output vertex_b, output vertex_c,
                    output last_of_run, input ready);
    modport sink   (input valid, input vertex_a, input vertex_b, input vertex_c,
                    input last_of_run, output ready);
endinterface

interface pta_cfg_if;
    logic                  valid;
    logic                  ready;
    pta_pkg::topo_t        topology;

    modport source (output valid, output topology, input ready);
    modport sink   (input valid, input topology, output ready);
endinterface

>>> rtl/pta_front.sv
// ----------------------------------------------------------------------------
// pta_front
// Accepts vertices, tracks batch state and classifies each vertex into a job.
// ----------------------------------------------------------------------------
module pta_front #(
    parameter int INDEX_WIDTH = pta_pkg::INDEX_WIDTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    pta_vtx_if.sink                 vtx,
    pta_cfg_if.sink                 cfg,
    output logic                    job_valid,
    input  logic                    job_ready,
    output pta_pkg::ctrl_t          job_ctrl,
    output logic [INDEX_WIDTH-1:0]  job_v0,
    output logic [INDEX_WIDTH-1:0]  job_v1,
    output logic [INDEX_WIDTH-1:0]  job_v2,
    output logic [INDEX_WIDTH-1:0]  job_cur
);

    pta_pkg::topo_t          topology_reg;
    logic [INDEX_WIDTH-1:0]  first_reg,   first_next;
    logic [INDEX_WIDTH-1:0]  older_reg,   older_next;
    logic [INDEX_WIDTH-1:0]  prev_reg,    prev_next;
    pta_pkg::seen_t          seen_reg,    seen_next;
    logic                    winding_reg, winding_next;

    logic [INDEX_WIDTH-1:0]  cur;
    logic                    emit;
    logic                    accept;
    logic                    non_degenerate;

    assign cfg.ready = 1'b1;
    assign vtx.ready = job_ready;
    assign accept    = vtx.valid && job_ready;
    assign cur       = vtx.vertex_index[INDEX_WIDTH-1:0];
    assign job_valid = vtx.valid && emit;
    assign job_cur   = cur;

    assign non_degenerate = (older_reg != prev_reg) && (prev_reg != cur) &&
                            (cur != older_reg);

    // classification
    always_comb
    begin
        emit                = 1'b0;
        job_ctrl.kind       = pta_pkg::KIND_LINES;
        job_ctrl.start_step = pta_pkg::STEP_BODY;
        job_ctrl.end_step   = pta_pkg::STEP_BODY;
        job_v0              = first_reg;
        job_v1              = prev_reg;
        job_v2              = older_reg;
        winding_next        = winding_reg;
        case (topology_reg)
            pta_pkg::TOPO_LINE_STRIP:
            begin
                emit = (seen_reg != pta_pkg::SEEN_NONE);
            end
            pta_pkg::TOPO_LINE_LOOP:
            begin
                emit = (seen_reg >= pta_pkg::SEEN_TWO);
                job_ctrl.start_step = (seen_reg == pta_pkg::SEEN_TWO) ?
                                      pta_pkg::STEP_HEAD : pta_pkg::STEP_BODY;
                job_ctrl.end_step   = vtx.end_of_batch ?
                                      pta_pkg::STEP_TAIL : pta_pkg::STEP_BODY;
            end
            pta_pkg::TOPO_TRI_STRIP:
            begin
                job_ctrl.kind = pta_pkg::KIND_TRIS;
                job_v0        = winding_reg ? prev_reg : older_reg;
                job_v1        = winding_reg ? older_reg : prev_reg;
                if (seen_reg >= pta_pkg::SEEN_TWO)
                begin
                    emit         = non_degenerate;
                    winding_next = ~winding_reg;
                end
            end
            pta_pkg::TOPO_TRI_FAN, pta_pkg::TOPO_POLYGONS:
            begin
                job_ctrl.kind = pta_pkg::KIND_TRIS;
                emit          = (seen_reg >= pta_pkg::SEEN_TWO);
            end
            pta_pkg::TOPO_QUADS:
            begin
                job_ctrl.kind       = pta_pkg::KIND_TRIS;
                job_ctrl.start_step = pta_pkg::STEP_HEAD;
                emit                = (seen_reg == pta_pkg::SEEN_MAX);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // batch state
    always_comb
    begin
        first_next = (seen_reg == pta_pkg::SEEN_NONE) ? cur : first_reg;
        older_next = prev_reg;
        prev_next  = cur;
        if (topology_reg == pta_pkg::TOPO_QUADS)
            seen_next = seen_reg + 2'd1;
        else if (seen_reg == pta_pkg::SEEN_MAX)
            seen_next = seen_reg;
        else
            seen_next = seen_reg + 2'd1;

        if ((topology_reg == pta_pkg::TOPO_POLYGONS) && vtx.end_of_polygon)
        begin
            seen_next  = pta_pkg::SEEN_NONE;
            first_next = '0;
        end

        if (vtx.end_of_batch)
        begin
            first_next   = '0;
            older_next   = '0;
            prev_next    = '0;
            seen_next    = pta_pkg::SEEN_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topology_reg <= pta_pkg::TOPO_LINE_STRIP;
            first_reg    <= '0;
            older_reg    <= '0;
            prev_reg     <= '0;
            seen_reg     <= pta_pkg::SEEN_NONE;
            winding_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                topology_reg <= cfg.topology;
            if (accept)
            begin
                first_reg   <= first_next;
                older_reg   <= older_next;
                prev_reg    <= prev_next;
                seen_reg    <= seen_next;
                winding_reg <= vtx.end_of_batch ? 1'b0 : winding_next;
            end
        end
    end

endmodule

>>> rtl/pta_queue.sv
// ----------------------------------------------------------------------------
// pta_queue
// Small register FIFO between front and back.
// ----------------------------------------------------------------------------
module pta_queue #(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH      = pta_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  logic [DATA_WIDTH-1:0]  push_data,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output logic [DATA_WIDTH-1:0]  pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    logic [DATA_WIDTH-1:0] slots_reg [DEPTH];
    logic [AW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]         cnt_reg,    cnt_next;
    logic                  do_push, do_pop;

    assign push_ready = (cnt_reg != FULL_CNT);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> rtl/pta_back.sv
// ----------------------------------------------------------------------------
// pta_back
// Expands queued jobs into primitives, one per cycle while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module pta_back #(
    parameter int INDEX_WIDTH = pta_pkg::INDEX_WIDTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    job_valid,
    output logic                    job_pop,
    input  pta_pkg::ctrl_t          job_ctrl,
    input  logic [INDEX_WIDTH-1:0]  job_v0,
    input  logic [INDEX_WIDTH-1:0]  job_v1,
    input  logic [INDEX_WIDTH-1:0]  job_v2,
    input  logic [INDEX_WIDTH-1:0]  job_cur,
    pta_prim_if.source              prim
);

    localparam int PW = pta_pkg::PORT_INDEX_WIDTH;

    logic                   prim_valid_reg;
    logic [PW-1:0]          a_reg, b_reg, c_reg;
    logic                   last_reg;
    logic                   active_reg;
    pta_pkg::step_t         step_reg;

    pta_pkg::step_t         step;
    logic                   load;
    logic                   done;
    logic [INDEX_WIDTH-1:0] a_sel, b_sel, c_sel;

    assign step    = active_reg ? step_reg : job_ctrl.start_step;
    assign load    = job_valid && (!prim_valid_reg || prim.ready);
    assign done    = (step == job_ctrl.end_step);
    assign job_pop = load && done;

    always_comb
    begin
        a_sel = job_v0;
        b_sel = job_v1;
        c_sel = '0;
        if (job_ctrl.kind == pta_pkg::KIND_TRIS)
        begin
            case (step)
                pta_pkg::STEP_HEAD:
                begin
                    a_sel = job_v0;
                    b_sel = job_v2;
                    c_sel = job_v1;
                end
                default:
                begin
                    a_sel = job_v0;
                    b_sel = job_v1;
                    c_sel = job_cur;
                end
            endcase
        end
        else
        begin
            case (step)
                pta_pkg::STEP_HEAD:
                begin
                    a_sel = job_v0;
                    b_sel = job_v1;
                end
                pta_pkg::STEP_BODY:
                begin
                    a_sel = job_v1;
                    b_sel = job_cur;
                end
                pta_pkg::STEP_TAIL:
                begin
                    a_sel = job_cur;
                    b_sel = job_v0;
                end
                default:
                begin
                    a_sel = job_v1;
                    b_sel = job_cur;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prim_valid_reg <= 1'b0;
            active_reg     <= 1'b0;
            step_reg       <= pta_pkg::STEP_HEAD;
        end
        else
        begin
            if (load)
            begin
                prim_valid_reg <= 1'b1;
                active_reg     <= !done;
                step_reg       <= step + 2'd1;
            end
            else if (prim.ready)
            begin
                prim_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg    <= PW'(a_sel);
            b_reg    <= PW'(b_sel);
            c_reg    <= PW'(c_sel);
            last_reg <= done;
        end
    end

    assign prim.valid       = prim_valid_reg;
    assign prim.vertex_a    = a_reg;
    assign prim.vertex_b    = b_reg;
    assign prim.vertex_c    = c_reg;
    assign prim.last_of_run = last_reg;

endmodule

>>> rtl/primitive_topology_assembler.sv
// ----------------------------------------------------------------------------
// primitive_topology_assembler
// Turns a vertex index stream into line or triangle primitives.
// ----------------------------------------------------------------------------
// One vertex index is taken per cycle whenever the four-entry job queue has
// room; the front end classifies it against the current topology (line strip,
// line loop, triangle strip, fan, quads, polygons) and the back end emits one
// primitive per cycle, unless the output stalls, from a registered output. A
// vertex gives at most one primitive, but a quad completion gives two and a
// line loop's opening/closing vertex two or three, so with a ready output the
// rate is one vertex per cycle for strips and fans and is set by the output
// port when several primitives follow from one vertex. A job passes through
// its queue slot and then the output register before its first primitive
// appears. Degenerate strip triangles are never queued. The topology
// register should only be written while the block is idle; writes are always
// accepted. last_of_run flags the final primitive of each vertex. Only the low
// INDEX_WIDTH bits of an index are kept; outputs are zero-extended.
// ----------------------------------------------------------------------------
module primitive_topology_assembler #(
    parameter int INDEX_WIDTH = pta_pkg::INDEX_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    pta_vtx_if.sink     vtx,
    pta_cfg_if.sink     cfg,
    pta_prim_if.source  prim
);

    // job = control word plus four vertex slots
    localparam int CTRL_W = $bits(pta_pkg::ctrl_t);
    localparam int JOB_W  = CTRL_W + 4 * INDEX_WIDTH;

    logic                    f_valid, f_ready;
    pta_pkg::ctrl_t          f_ctrl;
    logic [INDEX_WIDTH-1:0]  f_v0, f_v1, f_v2, f_cur;

    logic                    b_valid, b_pop;
    logic [JOB_W-1:0]        b_data;
    pta_pkg::ctrl_t          b_ctrl;
    logic [INDEX_WIDTH-1:0]  b_v0, b_v1, b_v2, b_cur;

    pta_front #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx       (vtx),
        .cfg       (cfg),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job_ctrl  (f_ctrl),
        .job_v0    (f_v0),
        .job_v1    (f_v1),
        .job_v2    (f_v2),
        .job_cur   (f_cur)
    );

    // decouples classification from primitive expansion
    pta_queue #(
        .DATA_WIDTH (JOB_W),
        .DEPTH      (pta_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_ctrl, f_v0, f_v1, f_v2, f_cur}),
        .pop_valid  (b_valid),
        .pop_ready  (b_pop),
        .pop_data   (b_data)
    );

    assign {b_ctrl, b_v0, b_v1, b_v2, b_cur} = b_data;

    pta_back #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (b_valid),
        .job_pop   (b_pop),
        .job_ctrl  (b_ctrl),
        .job_v0    (b_v0),
        .job_v1    (b_v1),
        .job_v2    (b_v2),
        .job_cur   (b_cur),
        .prim      (prim)
    );

endmodule

>>> tb/sv/pta_primitive_checker.sv
// ----------------------------------------------------------------------------
// pta_primitive_checker
// Passive scoreboard for the primitive topology assembler: it follows the
// topology writes and vertex transfers, works out the primitives each vertex
// must give and compares every primitive transfer against the oldest one.
// ----------------------------------------------------------------------------
module pta_primitive_checker #(
    parameter int INDEX_WIDTH = pta_pkg::INDEX_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 vtx_valid,
    input  logic                                 vtx_ready,
    input  logic [pta_pkg::PORT_INDEX_WIDTH-1:0] vtx_index,
    input  logic                                 vtx_end_of_batch,
    input  logic                                 vtx_end_of_polygon,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  pta_pkg::topo_t                       cfg_topology,
    input  logic                                 prim_valid,
    input  logic                                 prim_ready,
    input  logic [pta_pkg::PORT_INDEX_WIDTH-1:0] prim_vertex_a,
    input  logic [pta_pkg::PORT_INDEX_WIDTH-1:0] prim_vertex_b,
    input  logic [pta_pkg::PORT_INDEX_WIDTH-1:0] prim_vertex_c,
    input  logic                                 prim_last_of_run,
    output int                                   errors,
    output int                                   pending,
    output int                                   vertices_seen,
    output int                                   prims_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [pta_pkg::PORT_INDEX_WIDTH-1:0] word_t;
    typedef logic [INDEX_WIDTH-1:0]               idx_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        logic  last;
    } prim_t;

    prim_t expected_prims[$];

    // Shadow of the assembler's topology register and vertex history
    pta_pkg::topo_t topo_copy;
    idx_t           first_v;
    idx_t           older_v;
    idx_t           prev_v;
    pta_pkg::seen_t seen;
    logic           winding;

    function automatic prim_t make_prim(idx_t a, idx_t b, idx_t c);
        prim_t p;
        p.a    = word_t'(a);
        p.b    = word_t'(b);
        p.c    = word_t'(c);
        p.last = 1'b0;
        return p;
    endfunction

    // Expected primitives for one vertex, then the history update
    task automatic assemble_vertex(input word_t raw, input logic eob, input logic eop);
        idx_t  cur;
        idx_t  head;
        prim_t run[$];
        cur  = raw[INDEX_WIDTH-1:0];
        head = (seen == pta_pkg::SEEN_NONE) ? cur : first_v;
        case (topo_copy)
            pta_pkg::TOPO_LINE_STRIP:
                if (seen != pta_pkg::SEEN_NONE)
                    run.insert(run.size(), make_prim(prev_v, cur, '0));
            pta_pkg::TOPO_LINE_LOOP:
            begin
                if (seen == pta_pkg::SEEN_TWO)
                    run.insert(run.size(), make_prim(first_v, prev_v, '0));
                if (seen >= pta_pkg::SEEN_TWO)
                begin
                    run.insert(run.size(), make_prim(prev_v, cur, '0));
                    if (eob)
                        run.insert(run.size(), make_prim(cur, first_v, '0));
                end
            end
            pta_pkg::TOPO_TRI_STRIP:
                if (seen >= pta_pkg::SEEN_TWO)
                begin
                    // degenerate triangles vanish but still flip the winding
                    if (older_v != prev_v && prev_v != cur && cur != older_v)
                        run.insert(run.size(),
                                   winding ? make_prim(prev_v, older_v, cur)
                                           : make_prim(older_v, prev_v, cur));
                    winding = ~winding;
                end
            pta_pkg::TOPO_TRI_FAN, pta_pkg::TOPO_POLYGONS:
                if (seen >= pta_pkg::SEEN_TWO)
                    run.insert(run.size(), make_prim(first_v, prev_v, cur));
            pta_pkg::TOPO_QUADS:
                if (seen == pta_pkg::SEEN_MAX)
                begin
                    run.insert(run.size(), make_prim(first_v, older_v, prev_v));
                    run.insert(run.size(), make_prim(first_v, prev_v, cur));
                end
            default: ;
        endcase

        first_v = head;
        older_v = prev_v;
        prev_v  = cur;
        if (topo_copy == pta_pkg::TOPO_QUADS)
            seen = seen + 2'd1;
        else if (seen != pta_pkg::SEEN_MAX)
            seen = seen + 2'd1;

        if (topo_copy == pta_pkg::TOPO_POLYGONS && eop)
        begin
            seen    = pta_pkg::SEEN_NONE;
            first_v = '0;
        end
        if (eob)
        begin
            first_v = '0;
            older_v = '0;
            prev_v  = '0;
            seen    = pta_pkg::SEEN_NONE;
            winding = 1'b0;
        end

        if (run.size() > 0)
            run[run.size()-1].last = 1'b1;
        foreach (run[i])
            expected_prims.insert(expected_prims.size(), run[i]);
    endtask

    task automatic report_field(input string name, input word_t want, input word_t got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        prim_t want;
        if (!rst_n)
        begin
            errors        = 0;
            pending       = 0;
            vertices_seen = 0;
            prims_seen    = 0;
            topo_copy     = pta_pkg::TOPO_LINE_STRIP;
            first_v       = '0;
            older_v       = '0;
            prev_v        = '0;
            seen          = pta_pkg::SEEN_NONE;
            winding       = 1'b0;
            expected_prims.delete();
        end
        else
        begin
            // output side first: a primitive can never stem from this edge's vertex
            if (prim_valid && prim_ready)
            begin
                prims_seen++;
                if (expected_prims.size() == 0)
                begin
                    $display("%0t ns: unexpected primitive, expected none, actual %h %h %h %b",
                             $time, prim_vertex_a, prim_vertex_b, prim_vertex_c,
                             prim_last_of_run);
                    errors++;
                end
                else
                begin
                    want = expected_prims.pop_front();
                    report_field("vertex_a", want.a, prim_vertex_a);
                    report_field("vertex_b", want.b, prim_vertex_b);
                    report_field("vertex_c", want.c, prim_vertex_c);
                    report_field("last_of_run", word_t'(want.last), word_t'(prim_last_of_run));
                end
            end
            if (cfg_valid && cfg_ready)
                topo_copy = cfg_topology;
            if (vtx_valid && vtx_ready)
            begin
                vertices_seen++;
                assemble_vertex(vtx_index, vtx_end_of_batch, vtx_end_of_polygon);
            end
            pending = expected_prims.size();
        end
    end

endmodule

>>> tb/sv/primitive_topology_assembler_test.sv
// ----------------------------------------------------------------------------
// primitive_topology_assembler_test
// Stimulus and verdict for the primitive topology assembler. A directed
// opening covers each topology and its corner cases; random phases then mix
// topology writes, batch shapes, index patterns and handshake idling, with a
// long output stall to fill the block. Checking lives in the checker.
// ----------------------------------------------------------------------------
module primitive_topology_assembler_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 10;
    localparam int RANDOM_ITEMS = 360;
    localparam int QUIET_ITEMS  = 40;    // tail of the run with no idling at all
    localparam int LONG_HOLD    = 64;    // receiver hold-off, well past the job queue depth
    localparam int HOLD_MARGIN  = 16;    // vertices that can still pass around one hold-off
    localparam int SETTLE       = 4;     // latency margin before a topology write
    localparam int DRAIN        = 8;

    // Phase order for the first eight random phases so every code is written,
    // unused codes included; extremes 0 and 7 come early.
    localparam pta_pkg::topo_t PHASE_ORDER [8] = '{3'd7, pta_pkg::TOPO_TRI_STRIP,
                                                   pta_pkg::TOPO_LINE_STRIP,
                                                   pta_pkg::TOPO_QUADS,
                                                   pta_pkg::TOPO_LINE_LOOP,
                                                   pta_pkg::TOPO_POLYGONS,
                                                   pta_pkg::TOPO_TRI_FAN, 3'd6};

    logic clk;
    logic rst_n;

    pta_vtx_if  vtx_ch ();
    pta_cfg_if  cfg_ch ();
    pta_prim_if prim_ch ();

    int errors;
    int pending;
    int vertices_seen;
    int prims_seen;

    // Idling controls shared by the sender and the receiver
    int   idle_pct;
    logic quiet;
    int   hold_requests;
    int   holds_served;
    int   topo_writes;

    primitive_topology_assembler #(
        .INDEX_WIDTH(pta_pkg::INDEX_WIDTH_DEFAULT)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .vtx  (vtx_ch),
        .cfg  (cfg_ch),
        .prim (prim_ch)
    );

    pta_primitive_checker #(
        .INDEX_WIDTH(pta_pkg::INDEX_WIDTH_DEFAULT)
    ) u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .vtx_valid         (vtx_ch.valid),
        .vtx_ready         (vtx_ch.ready),
        .vtx_index         (vtx_ch.vertex_index),
        .vtx_end_of_batch  (vtx_ch.end_of_batch),
        .vtx_end_of_polygon(vtx_ch.end_of_polygon),
        .cfg_valid         (cfg_ch.valid),
        .cfg_ready         (cfg_ch.ready),
        .cfg_topology      (cfg_ch.topology),
        .prim_valid        (prim_ch.valid),
        .prim_ready        (prim_ch.ready),
        .prim_vertex_a     (prim_ch.vertex_a),
        .prim_vertex_b     (prim_ch.vertex_b),
        .prim_vertex_c     (prim_ch.vertex_c),
        .prim_last_of_run  (prim_ch.last_of_run),
        .errors            (errors),
        .pending           (pending),
        .vertices_seen     (vertices_seen),
        .prims_seen        (prims_seen)
    );

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // The slowest honest run ends far before this watchdog fires.
    initial
    begin
        #5_000_000;
        $display("[primitive_topology_assembler] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready bursts, plus long hold-offs on request.
    // Everything changes on the falling edge.
    // ------------------------------------------------------------------------
    initial
    begin
        prim_ch.ready = 1'b0;
        holds_served  = 0;
        forever
        begin
            @(negedge clk);
            if (holds_served < hold_requests)
            begin
                // long stall so the job queue fills and vtx.ready drops
                prim_ch.ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                holds_served++;
            end
            else if (!quiet && $urandom_range(0, 99) < idle_pct)
            begin
                prim_ch.ready = 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge clk);
            end
            else
                prim_ch.ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers; all are entered and left on a falling edge.
    // ------------------------------------------------------------------------

    // Offer one vertex and hold it until the transfer. valid is left high so
    // back-to-back vertices keep it asserted; callers lower it when done.
    task automatic offer_vertex(input logic [pta_pkg::PORT_INDEX_WIDTH-1:0] idx,
                                input logic eob, input logic eop);
        if (!quiet && $urandom_range(0, 99) < idle_pct)
        begin
            vtx_ch.valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        vtx_ch.valid          = 1'b1;
        vtx_ch.vertex_index   = idx;
        vtx_ch.end_of_batch   = eob;
        vtx_ch.end_of_polygon = eop;
        do
            @(posedge clk);
        while (!vtx_ch.ready);
        @(negedge clk);
    endtask

    // Topology writes only once the block has nothing left in flight
    task automatic write_topology(input pta_pkg::topo_t topo);
        vtx_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        // a vertex that gives nothing may still be inside the pipe
        repeat (SETTLE) @(negedge clk);
        cfg_ch.valid    = 1'b1;
        cfg_ch.topology = topo;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        topo_writes++;
    endtask

    // Index mix: small values make strip degenerates common, the rest
    // exercises every bit and the ends of the range.
    function automatic logic [pta_pkg::PORT_INDEX_WIDTH-1:0] pick_index();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return pta_pkg::PORT_INDEX_WIDTH'($urandom_range(0, 7));
        else if (sel < 7)
            return pta_pkg::PORT_INDEX_WIDTH'($urandom());
        else if (sel == 7)
            return {pta_pkg::PORT_INDEX_WIDTH{1'b1}}
                   - pta_pkg::PORT_INDEX_WIDTH'($urandom_range(0, 3));
        else
            return ($urandom_range(0, 1) == 0) ? '0 : {pta_pkg::PORT_INDEX_WIDTH{1'b1}};
    endfunction

    // ------------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int             items_sent;
        int             phase;
        int             budget;
        int             sent_here;
        int             batch_len;
        logic           open_tail;
        logic           eob;
        logic           eop;
        pta_pkg::topo_t topo;

        // every input known from time zero
        vtx_ch.valid          = 1'b0;
        vtx_ch.vertex_index   = '0;
        vtx_ch.end_of_batch   = 1'b0;
        vtx_ch.end_of_polygon = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.topology       = pta_pkg::TOPO_LINE_STRIP;
        idle_pct              = 20;
        quiet                 = 1'b0;
        hold_requests         = 0;
        topo_writes           = 0;
        items_sent            = 0;

        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed opening ----
        // line strip from reset: both index extremes, polygon mark as noise
        offer_vertex('0, 1'b0, 1'b1);
        offer_vertex('1, 1'b1, 1'b0);

        // line loop: a two-vertex loop gives nothing, a three-vertex one closes last
        write_topology(pta_pkg::TOPO_LINE_LOOP);
        offer_vertex(32'd5, 1'b0, 1'b0);
        offer_vertex(32'd9, 1'b1, 1'b0);
        offer_vertex(32'd1, 1'b0, 1'b0);
        offer_vertex(32'd2, 1'b0, 1'b0);
        offer_vertex(32'd3, 1'b1, 1'b0);

        // triangle strip: first triangle degenerate, winding still flips
        write_topology(pta_pkg::TOPO_TRI_STRIP);
        offer_vertex(32'd4, 1'b0, 1'b0);
        offer_vertex(32'd4, 1'b0, 1'b0);
        offer_vertex(32'd7, 1'b0, 1'b0);
        offer_vertex(32'd8, 1'b1, 1'b0);

        // fan
        write_topology(pta_pkg::TOPO_TRI_FAN);
        offer_vertex(32'd10, 1'b0, 1'b0);
        offer_vertex(32'd11, 1'b0, 1'b0);
        offer_vertex(32'd12, 1'b1, 1'b0);

        // quads: one full quad then a leftover vertex at batch end
        write_topology(pta_pkg::TOPO_QUADS);
        offer_vertex(32'd1, 1'b0, 1'b0);
        offer_vertex(32'd2, 1'b0, 1'b0);
        offer_vertex(32'd3, 1'b0, 1'b0);
        offer_vertex(32'd4, 1'b0, 1'b0);
        offer_vertex(32'd5, 1'b1, 1'b0);

        // polygons: a short polygon, then one ending together with the batch
        write_topology(pta_pkg::TOPO_POLYGONS);
        offer_vertex(32'd1, 1'b0, 1'b0);
        offer_vertex(32'd2, 1'b0, 1'b1);
        offer_vertex(32'd3, 1'b0, 1'b0);
        offer_vertex(32'd4, 1'b0, 1'b0);
        offer_vertex(32'hFFFF_FFFF, 1'b1, 1'b1);

        // ---- random phases ----
        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (phase < 8)
                topo = PHASE_ORDER[phase];
            else if ($urandom_range(0, 9) == 0)
                topo = pta_pkg::topo_t'($urandom_range(6, 7));
            else
                topo = pta_pkg::topo_t'($urandom_range(0, 5));
            write_topology(topo);

            // some phases idle hard, some lightly, some not at all
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 15;
                default: idle_pct = 40;
            endcase
            // hold-offs stay clear of the quiet tail
            if ((phase == 1 || phase == 9) &&
                (items_sent + HOLD_MARGIN < RANDOM_ITEMS - QUIET_ITEMS))
                hold_requests++;

            budget    = $urandom_range(20, 45);
            // now and then a phase ends mid-batch, so the next topology reads
            // leftover state
            open_tail = ($urandom_range(0, 4) == 0);
            sent_here = 0;
            while (sent_here < budget && items_sent < RANDOM_ITEMS)
            begin
                batch_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                       : $urandom_range(4, 12);
                for (int k = 0; k < batch_len; k++)
                begin
                    eob = (k == batch_len - 1);
                    if (open_tail && sent_here + batch_len - k >= budget)
                        eob = 1'b0;
                    if (topo == pta_pkg::TOPO_POLYGONS)
                        eop = ($urandom_range(0, 3) == 0);
                    else
                        eop = ($urandom_range(0, 7) == 0);
                    quiet = (items_sent >= RANDOM_ITEMS - QUIET_ITEMS);
                    offer_vertex(pick_index(), eob, eop);
                    items_sent++;
                    sent_here++;
                end
            end
            phase++;
        end
        vtx_ch.valid = 1'b0;

        // ---- drain and verdict ----
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);

        $display("Run covered %0d vertex transfers and %0d primitive transfers", vertices_seen,
                 prims_seen);
        $display("across %0d topology writes, every topology code and %0d long output stalls.",
                 topo_writes, holds_served);
        if (errors == 0 && pending == 0)
            $display("[primitive_topology_assembler] OK");
        else
            $display("[primitive_topology_assembler] ERROR");
        $finish;
    end

endmodule
